// ----- rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds on every clock edge outside reset
`define CHK_HOLDS(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("check failed");

// condition implies a property on the following edge
`define CHK_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("check failed");

`endif

// ----- rtl/pcbc_pkg.sv -----
`default_nettype none

package pcbc_pkg;

  localparam int COUNT_BITS_DEF = 16;
  localparam int MID_DEPTH_DEF = 4;
  localparam int OUT_DEPTH_DEF = 4;

  localparam int OUT_W = 16;
  localparam int WIDE_W = 40;
  localparam logic [OUT_W-1:0] OUT_MAX = 16'hFFFF;
  localparam logic [15:0] LEN_MAX = 16'hFFFF;

  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT = 8'h2E;
  localparam logic [7:0] CH_0 = 8'h30;
  localparam logic [7:0] CH_9 = 8'h39;
  localparam logic [7:0] CH_UA = 8'h41;
  localparam logic [7:0] CH_UC = 8'h43;
  localparam logic [7:0] CH_UG = 8'h47;
  localparam logic [7:0] CH_UN = 8'h4E;
  localparam logic [7:0] CH_UT = 8'h54;
  localparam logic [7:0] CH_LA = 8'h61;
  localparam logic [7:0] CH_LC = 8'h63;
  localparam logic [7:0] CH_LG = 8'h67;
  localparam logic [7:0] CH_LN = 8'h6E;
  localparam logic [7:0] CH_LT = 8'h74;

  localparam int IDX_A = 0;
  localparam int IDX_C = 1;
  localparam int IDX_G = 2;
  localparam int IDX_T = 3;
  localparam int IDX_N = 4;
  localparam int IDX_DEL = 5;

  localparam logic [4:0] CODE_A = 5'd0;
  localparam logic [4:0] CODE_C = 5'd1;
  localparam logic [4:0] CODE_G = 5'd2;
  localparam logic [4:0] CODE_T = 5'd3;
  localparam logic [4:0] CODE_N = 5'd4;
  localparam logic [4:0] CODE_GAP = 5'd5;
  localparam logic [4:0] CODE_R = 5'd6;
  localparam logic [4:0] CODE_Y = 5'd7;
  localparam logic [4:0] CODE_K = 5'd8;
  localparam logic [4:0] CODE_M = 5'd9;
  localparam logic [4:0] CODE_S = 5'd10;
  localparam logic [4:0] CODE_W = 5'd11;
  localparam logic [4:0] CODE_B = 5'd12;
  localparam logic [4:0] CODE_D = 5'd13;
  localparam logic [4:0] CODE_H = 5'd14;
  localparam logic [4:0] CODE_V = 5'd15;
  localparam logic [4:0] CODE_X = 5'd16;

  typedef struct packed {
    logic [4:0]       consensus_code;
    logic [OUT_W-1:0] raw_coverage;
    logic [OUT_W-1:0] count_a;
    logic [OUT_W-1:0] count_c;
    logic [OUT_W-1:0] count_g;
    logic [OUT_W-1:0] count_t;
    logic [OUT_W-1:0] count_deletions;
    logic [OUT_W-1:0] count_unknown;
    logic [OUT_W-1:0] count_insertions;
  } result_t;

  function automatic logic [OUT_W-1:0] clip16(input logic [WIDE_W-1:0] v);
    return (v > WIDE_W'(OUT_MAX)) ? OUT_MAX : v[OUT_W-1:0];
  endfunction

  // mask bit order: A, C, G, T, N, deletion
  function automatic logic [4:0] consensus_of(input logic [5:0] mask);
    logic [4:0] code;
    code = ($countones(mask) == 4) ? CODE_N : CODE_X;
    case (mask)
      6'h01: code = CODE_A;
      6'h02: code = CODE_C;
      6'h04: code = CODE_G;
      6'h08: code = CODE_T;
      6'h10: code = CODE_N;
      6'h20: code = CODE_GAP;
      6'h05: code = CODE_R;
      6'h0A: code = CODE_Y;
      6'h0C: code = CODE_K;
      6'h03: code = CODE_M;
      6'h06: code = CODE_S;
      6'h09: code = CODE_W;
      6'h0E: code = CODE_B;
      6'h0D: code = CODE_D;
      6'h0B: code = CODE_H;
      6'h07: code = CODE_V;
      default: ;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/pcbc_fifo.sv -----
`default_nettype none
`include "assert_macros.svh"

module pcbc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  input  wire logic [WIDTH-1:0]           wr_data,
  input  wire logic                       pop,
  output logic      [WIDTH-1:0]           rd_data,
  output logic                            empty,
  output logic                            full,
  output logic      [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic pop_ok;
  logic push_ok;

  assign empty = (count == '0);
  assign full = (count == CW'(DEPTH));
  assign pop_ok = pop && !empty;
  assign push_ok = push && (!full || pop_ok);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop_ok) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push_ok && !pop_ok) begin
        count <= count + CW'(1);
      end else if (pop_ok && !push_ok) begin
        count <= count - CW'(1);
      end
    end
  end

  `CHK_HOLDS(a_count_bound, clk, rst, count <= CW'(DEPTH))
  `CHK_NEXT(a_push_fills, clk, rst, push && !full && !pop, !empty)

endmodule

`default_nettype wire

// ----- rtl/pcbc_front.sv -----
`default_nettype none
`include "assert_macros.svh"

module pcbc_front #(
  parameter int COUNT_BITS = pcbc_pkg::COUNT_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      push,
  input  wire logic [7:0]                symbol,
  input  wire logic                      symbol_valid,
  input  wire logic [7:0]                reference_base,
  input  wire logic                      column_end,
  input  wire logic                      rec_full,
  output logic                           rec_push,
  output logic      [8*COUNT_BITS+7:0]   rec_data
);

  import pcbc_pkg::*;

  localparam int CB = COUNT_BITS;
  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_DIGITS = 2'd1;
  localparam logic [1:0] MODE_SKIP = 2'd2;

  logic [1:0] mode;
  logic [1:0] mode_next;
  logic [15:0] acc;
  logic [15:0] acc_next;
  logic [15:0] skip;
  logic [15:0] skip_next;
  logic [15:0] skip_dec;
  logic [19:0] acc_ext;
  logic [4:0][CB-1:0] cnt;
  logic [4:0][CB-1:0] cnt_next;
  logic [CB-1:0] match;
  logic [CB-1:0] match_next;
  logic [CB-1:0] del;
  logic [CB-1:0] del_next;
  logic [CB-1:0] ins;
  logic [CB-1:0] ins_next;
  logic take;
  logic do_normal;
  logic is_digit;

  function automatic logic [CB-1:0] sat_inc(input logic [CB-1:0] v);
    return (v == '1) ? v : v + CB'(1);
  endfunction

  assign take = push && !rec_full;
  assign is_digit = (symbol >= CH_0) && (symbol <= CH_9);
  assign acc_ext = 20'({acc, 3'b000}) + 20'({acc, 1'b0}) + 20'(symbol - CH_0);
  assign skip_dec = (skip != '0) ? skip - 16'd1 : skip;

  always_comb begin
    mode_next = mode;
    acc_next = acc;
    skip_next = skip;
    cnt_next = cnt;
    match_next = match;
    del_next = del;
    ins_next = ins;
    do_normal = 1'b0;
    if (take && symbol_valid) begin
      unique case (mode)
        MODE_DIGITS: begin
          if (is_digit) begin
            acc_next = (acc_ext > 20'(LEN_MAX)) ? LEN_MAX : acc_ext[15:0];
          end else if (acc == '0) begin
            mode_next = MODE_NORMAL;
            do_normal = 1'b1;
          end else begin
            skip_next = acc - 16'd1;
            acc_next = '0;
            mode_next = (acc != 16'd1) ? MODE_SKIP : MODE_NORMAL;
          end
        end
        MODE_SKIP: begin
          skip_next = skip_dec;
          if (skip_dec == '0) begin
            mode_next = MODE_NORMAL;
          end
        end
        default: begin
          mode_next = MODE_NORMAL;
          do_normal = 1'b1;
        end
      endcase
      if (do_normal) begin
        case (symbol)
          CH_PLUS: begin
            ins_next = sat_inc(ins);
            mode_next = MODE_DIGITS;
            acc_next = '0;
          end
          CH_MINUS: begin
            del_next = sat_inc(del);
            mode_next = MODE_DIGITS;
            acc_next = '0;
          end
          CH_DOT, CH_COMMA: match_next = sat_inc(match);
          CH_UA, CH_LA: cnt_next[IDX_A] = sat_inc(cnt[IDX_A]);
          CH_UC, CH_LC: cnt_next[IDX_C] = sat_inc(cnt[IDX_C]);
          CH_UG, CH_LG: cnt_next[IDX_G] = sat_inc(cnt[IDX_G]);
          CH_UT, CH_LT: cnt_next[IDX_T] = sat_inc(cnt[IDX_T]);
          CH_UN, CH_LN: cnt_next[IDX_N] = sat_inc(cnt[IDX_N]);
          default: ;
        endcase
      end
    end
  end

  // column snapshot after this word's update
  assign rec_push = take && column_end;
  assign rec_data = {reference_base, ins_next, del_next, match_next, cnt_next};

  always_ff @(posedge clk) begin
    if (rst || (take && column_end)) begin
      mode <= MODE_NORMAL;
      acc <= '0;
      skip <= '0;
      cnt <= '0;
      match <= '0;
      del <= '0;
      ins <= '0;
    end else if (take) begin
      mode <= mode_next;
      acc <= acc_next;
      skip <= skip_next;
      cnt <= cnt_next;
      match <= match_next;
      del <= del_next;
      ins <= ins_next;
    end
  end

  `CHK_HOLDS(a_skip_nonzero, clk, rst, (mode == MODE_SKIP) |-> (skip != '0))

endmodule

`default_nettype wire

// ----- rtl/pcbc_back.sv -----
`default_nettype none
`include "assert_macros.svh"

module pcbc_back #(
  parameter int COUNT_BITS = pcbc_pkg::COUNT_BITS_DEF,
  parameter int OUT_DEPTH = pcbc_pkg::OUT_DEPTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      rec_empty,
  input  wire logic [8*COUNT_BITS+7:0]   rec_data,
  output logic                           rec_pop,
  input  wire logic                      res_pop,
  output logic                           res_empty,
  output pcbc_pkg::result_t              res
);

  import pcbc_pkg::*;

  localparam int CB = COUNT_BITS;
  localparam int SW = CB + 1;
  localparam int CVW = CB + 3;
  localparam int QCW = $clog2(OUT_DEPTH + 1);
  localparam int OCW = QCW + 1;
  localparam int RW = $bits(result_t);

  logic [7:0] rec_ref;
  logic [5:0][CB-1:0] n_sel;
  logic [5:0][CB-1:0] n1;
  logic [CB-1:0] ins1;
  logic v1;
  logic [5:0] mask_c;
  logic [5:0] mask2;
  logic [SW-1:0] sum01;
  logic [SW-1:0] sum23;
  logic [SW-1:0] sum45;
  logic [5:0][OUT_W-1:0] clip2;
  logic [OUT_W-1:0] ins2;
  logic v2;
  logic [CVW-1:0] cov;
  result_t res_in;
  logic [RW-1:0] res_vec;
  logic res_full;
  logic [QCW-1:0] res_count;
  logic [OCW-1:0] occ;
  logic res_pop_fire;

  assign rec_ref = rec_data[8*CB +: 8];
  assign res_pop_fire = res_pop && !res_empty;
  assign occ = OCW'(res_count) + OCW'(v1) + OCW'(v2);
  // issue only when the result queue has room for everything in flight
  assign rec_pop = !rec_empty && ((occ < OCW'(OUT_DEPTH)) || res_pop_fire);

  always_comb begin
    for (int k = 0; k < 5; k++) begin
      n_sel[k] = rec_data[k*CB +: CB];
    end
    n_sel[IDX_DEL] = rec_data[6*CB +: CB];
    case (rec_ref)
      CH_UA: n_sel[IDX_A] = rec_data[5*CB +: CB];
      CH_UC: n_sel[IDX_C] = rec_data[5*CB +: CB];
      CH_UG: n_sel[IDX_G] = rec_data[5*CB +: CB];
      CH_UT: n_sel[IDX_T] = rec_data[5*CB +: CB];
      default: ;
    endcase
  end

  // a symbol is in the tie set when no other count beats it
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      mask_c[i] = 1'b1;
      for (int j = 0; j < 6; j++) begin
        if (n1[i] < n1[j]) begin
          mask_c[i] = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= rec_pop;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_pop) begin
      n1 <= n_sel;
      ins1 <= rec_data[7*CB +: CB];
    end
    if (v1) begin
      mask2 <= mask_c;
      sum01 <= SW'(n1[0]) + SW'(n1[1]);
      sum23 <= SW'(n1[2]) + SW'(n1[3]);
      sum45 <= SW'(n1[4]) + SW'(n1[5]);
      for (int k = 0; k < 6; k++) begin
        clip2[k] <= clip16(WIDE_W'(n1[k]));
      end
      ins2 <= clip16(WIDE_W'(ins1));
    end
  end

  assign cov = CVW'(sum01) + CVW'(sum23) + CVW'(sum45);

  always_comb begin
    res_in.consensus_code = consensus_of(mask2);
    res_in.raw_coverage = clip16(WIDE_W'(cov));
    res_in.count_a = clip2[IDX_A];
    res_in.count_c = clip2[IDX_C];
    res_in.count_g = clip2[IDX_G];
    res_in.count_t = clip2[IDX_T];
    res_in.count_deletions = clip2[IDX_DEL];
    res_in.count_unknown = clip2[IDX_N];
    res_in.count_insertions = ins2;
  end

  pcbc_fifo #(
    .WIDTH (RW),
    .DEPTH (OUT_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .push    (v2),
    .wr_data (res_in),
    .pop     (res_pop),
    .rd_data (res_vec),
    .empty   (res_empty),
    .full    (res_full),
    .count   (res_count)
  );

  assign res = result_t'(res_vec);

  `CHK_HOLDS(a_no_push_when_full, clk, rst, v2 |-> !res_full)
  `CHK_HOLDS(a_occ_bound, clk, rst, occ <= OCW'(OUT_DEPTH))

endmodule

`default_nettype wire

// ----- rtl/pileup_column_base_counter.sv -----
// Pileup column base counter: takes one base-string character per clock
// through a push/full port, parsing indel markers and counting A/C/G/T/N,
// matches and indels per column; the word that carries column_end closes
// the column, and its result (IUPAC consensus code, raw coverage and the
// per-symbol counts, clipped to 16 bits) reaches empty/pop via the record
// queue, both back-end register stages and the result queue. The front
// update handles one character every clock while full is low, which rises
// only while the short record queue holds MID_DEPTH unfinished columns;
// it feeds the two-stage consensus back end, which finishes one column per
// clock while the OUT_DEPTH-word result queue, holding results until popped, has room.
`default_nettype none

module pileup_column_base_counter #(
  parameter int COUNT_BITS = pcbc_pkg::COUNT_BITS_DEF,
  parameter int MID_DEPTH = pcbc_pkg::MID_DEPTH_DEF,
  parameter int OUT_DEPTH = pcbc_pkg::OUT_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  symbol,
  input  wire logic        symbol_valid,
  input  wire logic [7:0]  reference_base,
  input  wire logic        column_end,
  output logic             empty,
  input  wire logic        pop,
  output logic [4:0]       consensus_code,
  output logic [15:0]      raw_coverage,
  output logic [15:0]      count_a,
  output logic [15:0]      count_c,
  output logic [15:0]      count_g,
  output logic [15:0]      count_t,
  output logic [15:0]      count_deletions,
  output logic [15:0]      count_unknown,
  output logic [15:0]      count_insertions
);

  import pcbc_pkg::*;

  localparam int REC_W = 8 * COUNT_BITS + 8;

  logic rec_push;
  logic [REC_W-1:0] rec_wdata;
  logic [REC_W-1:0] rec_rdata;
  logic rec_empty;
  logic rec_full;
  logic rec_pop;
  result_t res;

  pcbc_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .symbol         (symbol),
    .symbol_valid   (symbol_valid),
    .reference_base (reference_base),
    .column_end     (column_end),
    .rec_full       (rec_full),
    .rec_push       (rec_push),
    .rec_data       (rec_wdata)
  );

  pcbc_fifo #(
    .WIDTH (REC_W),
    .DEPTH (MID_DEPTH)
  ) u_rec_q (
    .clk     (clk),
    .rst     (rst),
    .push    (rec_push),
    .wr_data (rec_wdata),
    .pop     (rec_pop),
    .rd_data (rec_rdata),
    .empty   (rec_empty),
    .full    (rec_full),
    .count   ()
  );

  pcbc_back #(
    .COUNT_BITS (COUNT_BITS),
    .OUT_DEPTH  (OUT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .rec_empty (rec_empty),
    .rec_data  (rec_rdata),
    .rec_pop   (rec_pop),
    .res_pop   (pop),
    .res_empty (empty),
    .res       (res)
  );

  assign full = rec_full;
  assign consensus_code = res.consensus_code;
  assign raw_coverage = res.raw_coverage;
  assign count_a = res.count_a;
  assign count_c = res.count_c;
  assign count_g = res.count_g;
  assign count_t = res.count_t;
  assign count_deletions = res.count_deletions;
  assign count_unknown = res.count_unknown;
  assign count_insertions = res.count_insertions;

endmodule

`default_nettype wire

// ----- tb/pcbc_checker.sv -----
`timescale 1ns / 1ps

module pcbc_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [7:0]  symbol,
  input  logic        symbol_valid,
  input  logic [7:0]  reference_base,
  input  logic        column_end,
  input  logic        empty,
  input  logic        pop,
  input  logic [4:0]  consensus_code,
  input  logic [15:0] raw_coverage,
  input  logic [15:0] count_a,
  input  logic [15:0] count_c,
  input  logic [15:0] count_g,
  input  logic [15:0] count_t,
  input  logic [15:0] count_deletions,
  input  logic [15:0] count_unknown,
  input  logic [15:0] count_insertions,
  output int          fail_count,
  output int          pending
);
  import pcbc_pkg::*;

  typedef enum logic [1:0] {
    MODE_NORMAL,
    MODE_DIGITS,
    MODE_SKIP
  } parse_mode_e;

  localparam logic [5:0] M_A = 6'b1 << IDX_A;
  localparam logic [5:0] M_C = 6'b1 << IDX_C;
  localparam logic [5:0] M_G = 6'b1 << IDX_G;
  localparam logic [5:0] M_T = 6'b1 << IDX_T;
  localparam logic [5:0] M_N = 6'b1 << IDX_N;

  parse_mode_e pmode;
  logic [15:0] indel_len;
  logic [15:0] skip_left;
  logic [15:0] base_tally [5];
  logic [15:0] match_tally;
  logic [15:0] del_tally;
  logic [15:0] ins_tally;
  result_t     column_q [$];
  result_t     got;
  result_t     want;

  initial fail_count = 0;

  function automatic logic [15:0] sat_bump(input logic [15:0] c);
    return (c == OUT_MAX) ? c : c + 16'd1;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned seen,
                                 input int unsigned wanted);
    $display("%0t: %s is %0d, expected %0d", $time, what, seen, wanted);
    fail_count++;
  endtask

  task automatic clear_column();
    pmode = MODE_NORMAL;
    indel_len = '0;
    skip_left = '0;
    for (int i = 0; i < 5; i++) base_tally[i] = '0;
    match_tally = '0;
    del_tally = '0;
    ins_tally = '0;
  endtask

  task automatic count_char(input logic [7:0] ch);
    case (ch)
      CH_PLUS: begin
        ins_tally = sat_bump(ins_tally);
        pmode = MODE_DIGITS;
        indel_len = '0;
      end
      CH_MINUS: begin
        del_tally = sat_bump(del_tally);
        pmode = MODE_DIGITS;
        indel_len = '0;
      end
      CH_DOT, CH_COMMA: match_tally = sat_bump(match_tally);
      CH_UA, CH_LA: base_tally[IDX_A] = sat_bump(base_tally[IDX_A]);
      CH_UC, CH_LC: base_tally[IDX_C] = sat_bump(base_tally[IDX_C]);
      CH_UG, CH_LG: base_tally[IDX_G] = sat_bump(base_tally[IDX_G]);
      CH_UT, CH_LT: base_tally[IDX_T] = sat_bump(base_tally[IDX_T]);
      CH_UN, CH_LN: base_tally[IDX_N] = sat_bump(base_tally[IDX_N]);
      default: ;
    endcase
  endtask

  task automatic take_symbol(input logic [7:0] ch);
    logic [31:0] grown;
    case (pmode)
      MODE_DIGITS: begin
        if (ch >= CH_0 && ch <= CH_9) begin
          grown = 32'(indel_len) * 32'd10 + (32'(ch) - 32'(CH_0));
          indel_len = (grown > 32'(LEN_MAX)) ? LEN_MAX : grown[15:0];
        end else if (indel_len == '0) begin
          pmode = MODE_NORMAL;
          count_char(ch);
        end else begin
          skip_left = indel_len - 16'd1;
          indel_len = '0;
          pmode = (skip_left != '0) ? MODE_SKIP : MODE_NORMAL;
        end
      end
      MODE_SKIP: begin
        if (skip_left > '0) skip_left = skip_left - 16'd1;
        if (skip_left == '0) pmode = MODE_NORMAL;
      end
      default: begin
        pmode = MODE_NORMAL;
        count_char(ch);
      end
    endcase
  endtask

  function automatic result_t close_column(input logic [7:0] ref_ch);
    logic [15:0] n [6];
    logic [19:0] cov;
    logic [15:0] best;
    int          ties;
    logic [5:0]  mask;
    logic [4:0]  code;
    result_t     r;
    for (int i = 0; i < 5; i++) n[i] = base_tally[i];
    n[IDX_DEL] = del_tally;
    case (ref_ch)
      CH_UA: n[IDX_A] = match_tally;
      CH_UC: n[IDX_C] = match_tally;
      CH_UG: n[IDX_G] = match_tally;
      CH_UT: n[IDX_T] = match_tally;
      default: ;
    endcase
    cov = '0;
    best = '0;
    ties = 0;
    mask = '0;
    for (int i = 0; i < 6; i++) begin
      cov = cov + 20'(n[i]);
      if (n[i] > best) begin
        best = n[i];
        ties = 1;
        mask = 6'b1 << i;
      end else if (n[i] == best) begin
        ties++;
        mask[i] = 1'b1;
      end
    end
    code = CODE_X;
    case (ties)
      1: begin
        case (mask)
          M_A: code = CODE_A;
          M_C: code = CODE_C;
          M_G: code = CODE_G;
          M_T: code = CODE_T;
          M_N: code = CODE_N;
          default: code = CODE_GAP;
        endcase
      end
      2: begin
        case (mask)
          M_A | M_G: code = CODE_R;
          M_C | M_T: code = CODE_Y;
          M_G | M_T: code = CODE_K;
          M_A | M_C: code = CODE_M;
          M_C | M_G: code = CODE_S;
          M_A | M_T: code = CODE_W;
          default: code = CODE_X;
        endcase
      end
      3: begin
        case (mask)
          M_C | M_G | M_T: code = CODE_B;
          M_A | M_G | M_T: code = CODE_D;
          M_A | M_C | M_T: code = CODE_H;
          M_A | M_C | M_G: code = CODE_V;
          default: code = CODE_X;
        endcase
      end
      4: code = CODE_N;
      default: code = CODE_X;
    endcase
    r.consensus_code = code;
    r.raw_coverage = (cov > 20'(OUT_MAX)) ? OUT_MAX : cov[15:0];
    r.count_a = n[IDX_A];
    r.count_c = n[IDX_C];
    r.count_g = n[IDX_G];
    r.count_t = n[IDX_T];
    r.count_deletions = n[IDX_DEL];
    r.count_unknown = n[IDX_N];
    r.count_insertions = ins_tally;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      clear_column();
      column_q.delete();
    end else begin
      if (push && !full) begin
        if (symbol_valid) take_symbol(symbol);
        if (column_end) begin
          column_q.push_back(close_column(reference_base));
          clear_column();
        end
      end
      if (pop && !empty) begin
        got = {consensus_code, raw_coverage, count_a, count_c, count_g, count_t,
               count_deletions, count_unknown, count_insertions};
        if (column_q.size() == 0) begin
          report_mismatch("unexpected word, coverage", got.raw_coverage, 0);
        end else begin
          want = column_q.pop_front();
          if (got.consensus_code !== want.consensus_code)
            report_mismatch("consensus_code", got.consensus_code, want.consensus_code);
          if (got.raw_coverage !== want.raw_coverage)
            report_mismatch("raw_coverage", got.raw_coverage, want.raw_coverage);
          if (got.count_a !== want.count_a)
            report_mismatch("count_a", got.count_a, want.count_a);
          if (got.count_c !== want.count_c)
            report_mismatch("count_c", got.count_c, want.count_c);
          if (got.count_g !== want.count_g)
            report_mismatch("count_g", got.count_g, want.count_g);
          if (got.count_t !== want.count_t)
            report_mismatch("count_t", got.count_t, want.count_t);
          if (got.count_deletions !== want.count_deletions)
            report_mismatch("count_deletions", got.count_deletions, want.count_deletions);
          if (got.count_unknown !== want.count_unknown)
            report_mismatch("count_unknown", got.count_unknown, want.count_unknown);
          if (got.count_insertions !== want.count_insertions)
            report_mismatch("count_insertions", got.count_insertions,
                            want.count_insertions);
        end
      end
    end
    pending = column_q.size();
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import pcbc_pkg::*;

  localparam int          RAND_WORDS = 1450;
  localparam int          HOLD_START = 400;
  localparam int          HOLD_CYCLES = 400;
  localparam int          DRAIN_CYCLES = 200;
  localparam int unsigned LIMIT = 3_000_000;

  logic        clk;
  logic        rst = 1'b1;
  logic        push;
  logic        full;
  logic [7:0]  symbol;
  logic        symbol_valid;
  logic [7:0]  reference_base;
  logic        column_end;
  logic        empty;
  logic        pop;
  logic [4:0]  consensus_code;
  logic [15:0] raw_coverage;
  logic [15:0] count_a;
  logic [15:0] count_c;
  logic [15:0] count_g;
  logic [15:0] count_t;
  logic [15:0] count_deletions;
  logic [15:0] count_unknown;
  logic [15:0] count_insertions;

  int          fail_count;
  int          pending;
  int unsigned cycle_count = 0;
  int          words_sent = 0;
  bit          hold_pending = 1'b0;
  bit          calm = 1'b0;
  logic [8:0]  column_body [$];
  string       bases = "ACGTNacgtn";

  pileup_column_base_counter u_top (
    .clk(clk), .rst(rst), .push(push), .full(full), .symbol(symbol),
    .symbol_valid(symbol_valid), .reference_base(reference_base),
    .column_end(column_end), .empty(empty), .pop(pop),
    .consensus_code(consensus_code), .raw_coverage(raw_coverage),
    .count_a(count_a), .count_c(count_c), .count_g(count_g), .count_t(count_t),
    .count_deletions(count_deletions), .count_unknown(count_unknown),
    .count_insertions(count_insertions)
  );

  pcbc_checker u_chk (
    .clk(clk), .rst(rst), .push(push), .full(full), .symbol(symbol),
    .symbol_valid(symbol_valid), .reference_base(reference_base),
    .column_end(column_end), .empty(empty), .pop(pop),
    .consensus_code(consensus_code), .raw_coverage(raw_coverage),
    .count_a(count_a), .count_c(count_c), .count_g(count_g), .count_t(count_t),
    .count_deletions(count_deletions), .count_unknown(count_unknown),
    .count_insertions(count_insertions), .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin : watchdog
    wait (cycle_count >= LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // offers one word and returns at the edge that takes it, push left high
  task automatic send_word(input logic [7:0] ch, input logic ok,
                           input logic [7:0] rb, input logic last);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      symbol <= 8'($urandom);
      symbol_valid <= 1'($urandom);
      reference_base <= 8'($urandom);
      column_end <= 1'($urandom);
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    symbol <= ch;
    symbol_valid <= ok;
    reference_base <= rb;
    column_end <= last;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic send_text(input string s, input logic [7:0] rb);
    for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b1, rb, i == s.len() - 1);
  endtask

  task automatic add_char(input logic [7:0] ch);
    if ($urandom_range(0, 24) == 0) column_body.push_back({1'b0, 8'($urandom)});
    column_body.push_back({1'b1, ch});
  endtask

  task automatic send_random_column();
    logic [7:0] rb;
    string      digits;
    int         target;
    int         r;
    int         ilen;
    column_body.delete();
    r = $urandom_range(0, 9);
    if (r < 7) rb = bases[$urandom_range(0, 3)];
    else if (r == 7) rb = bases[$urandom_range(5, 8)];
    else if (r == 8) rb = CH_UN;
    else rb = 8'($urandom);
    r = $urandom_range(0, 99);
    if (r < 2) target = 0;
    else if (r < 85) target = $urandom_range(1, 10);
    else if (r < 97) target = $urandom_range(11, 30);
    else target = $urandom_range(31, 80);
    while (column_body.size() < target) begin
      r = $urandom_range(0, 99);
      if (r < 30) add_char(bases[$urandom_range(0, 4)]);
      else if (r < 45) add_char(bases[$urandom_range(5, 9)]);
      else if (r < 63) add_char($urandom_range(0, 1) ? CH_DOT : CH_COMMA);
      else if (r < 73) begin
        add_char($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
        r = $urandom_range(0, 99);
        if (r < 10) ilen = 0;
        else if (r < 80) ilen = $urandom_range(1, 9);
        else if (r < 97) ilen = $urandom_range(10, 40);
        else ilen = $urandom_range(60000, 99999);
        if (ilen > 0) begin
          digits = $sformatf("%0d", ilen);
          for (int i = 0; i < digits.len(); i++) add_char(digits[i]);
          // long indels run short so the skip eats later text or the column end
          for (int i = 0; i < ilen && i < 14; i++) add_char(bases[$urandom_range(0, 9)]);
        end
      end else if (r < 80) begin
        add_char(8'h5E);
        add_char(8'($urandom_range(33, 126)));
      end else if (r < 85) add_char($urandom_range(0, 1) ? 8'h24 : 8'h2A);
      else if (r < 92) add_char(8'($urandom_range(CH_0, CH_9)));
      else add_char(8'($urandom));
    end
    // end word without a symbol
    if (column_body.size() == 0 || $urandom_range(0, 11) == 0)
      column_body.push_back({1'b0, 8'($urandom)});
    for (int i = 0; i < column_body.size(); i++) begin
      send_word(column_body[i][7:0], column_body[i][8], rb, i == column_body.size() - 1);
      if (column_body[i][8]) words_sent++;
    end
  endtask

  initial begin : receiver
    int stall_left;
    stall_left = 0;
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (rst) begin
        pop <= 1'b0;
      end else if (calm) begin
        pop <= 1'b1;
      end else if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        pop <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  initial begin : stimulus
    bit held;
    held = 1'b0;
    push <= 1'b0;
    symbol <= '0;
    symbol_valid <= 1'b0;
    reference_base <= '0;
    column_end <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send_word(8'h00, 1'b0, CH_UA, 1'b1);
    send_text("N", CH_UG);
    send_text("-A", CH_UT);
    send_text("+2ACg", CH_UC);
    send_text(".,aT", CH_UA);
    send_text("+12AC", CH_UT);
    send_text("AG", CH_LC);
    send_text("^]$*C", CH_UT);
    send_word(8'hFF, 1'b1, 8'hFF, 1'b0);
    send_word(8'h00, 1'b1, 8'h00, 1'b1);

    // indel length past the limit, column closed inside the indel
    calm = 1'b1;
    send_text("+70000", CH_UC);
    send_word(CH_UT, 1'b1, CH_UC, 1'b1);
    calm = 1'b0;

    words_sent = 0;
    while (words_sent < RAND_WORDS) begin
      calm = ($urandom_range(0, 9) == 0);
      if (!held && words_sent >= HOLD_START) begin
        hold_pending = 1'b1;
        held = 1'b1;
      end
      send_random_column();
    end
    calm = 1'b0;
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
